[rtl/scc_pkg.sv]
// Package for the sensor frame CRC checker: frame constants, status codes, CRC step.
`default_nettype none

package scc_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  HDR_FUNC  = 8'h03;
    localparam logic [7:0]  HDR_COUNT = 8'h04;
    localparam int unsigned SIGN_BIT  = 15;
    localparam logic [14:0] MAG_MASK  = 15'h7FFF;

    // Byte positions within one reply frame
    localparam logic [2:0] POS_FUNC     = 3'd0;
    localparam logic [2:0] POS_COUNT    = 3'd1;
    localparam logic [2:0] POS_HUM_HI   = 3'd2;
    localparam logic [2:0] POS_HUM_LO   = 3'd3;
    localparam logic [2:0] POS_TEMP_HI  = 3'd4;
    localparam logic [2:0] POS_TEMP_LO  = 3'd5;
    localparam logic [2:0] POS_CRC_LO   = 3'd6;
    localparam logic [2:0] POS_CRC_HI   = 3'd7;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_HEADER = 2'd1,
        STATUS_CRC    = 2'd2
    } frame_status_t;

    typedef struct packed {
        frame_status_t      status;
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
    } result_t;

    // One byte of CRC-16/MODBUS, reflected, eight shift steps unrolled
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

[rtl/sensor_frame_crc_check.sv]
// Sensor reply frame checker: the top level and its whole datapath.
//
// Usage: reply bytes enter on the input channel (rx_byte, frame_start) under
// in_valid / in_stall; each accepted word is one byte of an 8-byte reply.
// frame_start marks byte 0 and drops any partial frame. On byte 7 one result
// word (frame_status, humidity_tenths, temperature_tenths) is presented on the
// output channel under out_valid / out_stall; other bytes give no result.
// The byte-7 result is registered in the result register, or in the skid
// register under a stall. Throughput: one byte per cycle while in_stall is
// low; the CRC step is combinational, between state and result registers.
// A full result register plus a one-word skid register let input keep
// flowing while the receiver stalls; in_stall rises only when the skid
// register is occupied, and falls once the receiver takes a word.
// Error results carry zero humidity and temperature; a header mismatch wins
// over a CRC mismatch.
// Reset: position returns to byte 0, the CRC to 0xFFFF, both output words
// are emptied. Frames run back to back without frame_start.
`default_nettype none

module sensor_frame_crc_check
    import scc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               frame_start,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              frame_status,
    output logic [15:0]             humidity_tenths,
    output logic signed [15:0]      temperature_tenths
);

    logic [2:0]  pos_reg,     pos_next;
    logic [15:0] crc_reg,     crc_next;
    logic        hdr_bad_reg, hdr_bad_next;
    logic [15:0] hum_reg,     hum_next;
    logic [15:0] temp_reg,    temp_next;
    logic [7:0]  crc_lo_reg,  crc_lo_next;

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     out_word_reg, out_word_next;
    result_t     skid_word_reg, skid_word_next;

    logic        accept;
    logic        res_valid;
    result_t     res_word;
    logic [2:0]  pos_eff;
    logic [15:0] crc_eff;
    logic        hdr_bad_eff;
    logic [15:0] crc_rx;
    logic [14:0] mag;

    assign accept = in_valid && !in_stall;
    assign in_stall = skid_valid_reg;

    // frame_start restarts the frame before the byte is taken
    assign pos_eff     = frame_start ? POS_FUNC : pos_reg;
    assign crc_eff     = frame_start ? CRC_INIT : crc_reg;
    assign hdr_bad_eff = frame_start ? 1'b0 : hdr_bad_reg;
    assign crc_rx      = {rx_byte, crc_lo_reg};
    assign mag         = temp_reg[14:0] & MAG_MASK;

    // Frame state update and result formation
    always_comb
    begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        hdr_bad_next = hdr_bad_reg;
        hum_next     = hum_reg;
        temp_next    = temp_reg;
        crc_lo_next  = crc_lo_reg;
        res_valid    = 1'b0;
        res_word     = '0;

        if (accept) begin
            pos_next     = pos_eff + 3'd1;
            crc_next     = crc_eff;
            hdr_bad_next = hdr_bad_eff;
            if (pos_eff < POS_CRC_LO) begin
                crc_next = crc_byte(crc_eff, rx_byte);
            end
            case (pos_eff)
                POS_FUNC:    if (rx_byte != HDR_FUNC) hdr_bad_next = 1'b1;
                POS_COUNT:   if (rx_byte != HDR_COUNT) hdr_bad_next = 1'b1;
                POS_HUM_HI:  hum_next = {rx_byte, hum_reg[7:0]};
                POS_HUM_LO:  hum_next = {hum_reg[15:8], rx_byte};
                POS_TEMP_HI: temp_next = {rx_byte, temp_reg[7:0]};
                POS_TEMP_LO: temp_next = {temp_reg[15:8], rx_byte};
                POS_CRC_LO:  crc_lo_next = rx_byte;
                POS_CRC_HI:
                begin
                    res_valid = 1'b1;
                    if (hdr_bad_eff) begin
                        res_word.status = STATUS_HEADER;
                    end else if (crc_rx != crc_eff) begin
                        res_word.status = STATUS_CRC;
                    end else begin
                        res_word.status   = STATUS_OK;
                        res_word.humidity = hum_reg;
                        if (temp_reg[SIGN_BIT]) begin
                            res_word.temperature = 16'sd0 - $signed({1'b0, mag});
                        end else begin
                            res_word.temperature = $signed({1'b0, mag});
                        end
                    end
                    crc_next     = CRC_INIT;
                    hdr_bad_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Output register with one-word skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (!out_valid_reg || !out_stall) begin
            if (skid_valid_reg) begin
                out_word_next   = skid_word_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_word_next  = res_word;
                out_valid_next = res_valid;
            end
        end else if (res_valid) begin
            skid_word_next  = res_word;
            skid_valid_next = 1'b1;
        end
    end

    // Control and frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg        <= POS_FUNC;
            crc_reg        <= CRC_INIT;
            hdr_bad_reg    <= 1'b0;
            hum_reg        <= '0;
            temp_reg       <= '0;
            crc_lo_reg     <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            hdr_bad_reg    <= hdr_bad_next;
            hum_reg        <= hum_next;
            temp_reg       <= temp_next;
            crc_lo_reg     <= crc_lo_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid          = out_valid_reg;
    assign frame_status       = out_word_reg.status;
    assign humidity_tenths    = out_word_reg.humidity;
    assign temperature_tenths = out_word_reg.temperature;

endmodule

`default_nettype wire

[sim/sensor_frame_crc_check_monitor.sv]
// Monitor for the sensor frame checker: predicts each reading and compares results.
`default_nettype none

module sensor_frame_crc_check_monitor
    import scc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               frame_start,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [1:0]         frame_status,
    input  wire logic [15:0]        humidity_tenths,
    input  wire logic signed [15:0] temperature_tenths,
    output int                      fail_count,
    output int                      pending_readings,
    output int                      readings_checked
);

    localparam int MAX_SHOWN = 40;

    typedef struct packed {
        frame_status_t status;
        logic [15:0]   humidity;
        logic [15:0]   temperature;
    } reading_t;

    // Shadow copy of the frame state
    logic [2:0]  next_pos;
    logic [15:0] crc_run;
    logic        hdr_err;
    logic [15:0] hum_word;
    logic [15:0] temp_word;
    logic [7:0]  crc_lo_rx;

    reading_t expected_readings[$];

    // One line per mismatch, capped so a broken run stays readable
    task automatic report_mismatch(input string what);
        fail_count = fail_count + 1;
        if (fail_count <= MAX_SHOWN) begin
            $display("MISMATCH @%0t: %s", $time, what);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        reading_t    want;
        logic [2:0]  pos;
        logic        fb;
        logic [15:0] rx_crc;
        if (!rst_n) begin
            next_pos = POS_FUNC;
            crc_run = CRC_INIT;
            hdr_err = 1'b0;
            hum_word = '0;
            temp_word = '0;
            crc_lo_rx = '0;
            expected_readings.delete();
            fail_count = 0;
            readings_checked = 0;
            pending_readings <= 0;
        end else begin
            // Result side first: a result never comes from the word taken this edge
            if (out_valid && !out_stall) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status=%0d hum=%h temp=%h",
                        frame_status, humidity_tenths, temperature_tenths));
                end else begin
                    want = expected_readings.pop_front();
                    readings_checked = readings_checked + 1;
                    if (frame_status !== want.status) begin
                        report_mismatch($sformatf("frame_status got %0d want %0d",
                            frame_status, want.status));
                    end
                    if (humidity_tenths !== want.humidity) begin
                        report_mismatch($sformatf("humidity_tenths got %h want %h",
                            humidity_tenths, want.humidity));
                    end
                    if (temperature_tenths !== want.temperature) begin
                        report_mismatch($sformatf("temperature_tenths got %h want %h",
                            temperature_tenths, want.temperature));
                    end
                end
            end

            // Word side: step the shadow frame state
            if (in_valid && !in_stall) begin
                if (frame_start) begin
                    next_pos = POS_FUNC;
                    crc_run = CRC_INIT;
                    hdr_err = 1'b0;
                end
                pos = next_pos;

                // Bitwise CRC: feedback is the low CRC bit against the next data bit
                if (pos < POS_CRC_LO) begin
                    for (int i = 0; i < 8; i++) begin
                        fb = crc_run[0] ^ rx_byte[i];
                        crc_run = {1'b0, crc_run[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
                    end
                end

                case (pos)
                    POS_FUNC:    if (rx_byte != HDR_FUNC) hdr_err = 1'b1;
                    POS_COUNT:   if (rx_byte != HDR_COUNT) hdr_err = 1'b1;
                    POS_HUM_HI:  hum_word[15:8] = rx_byte;
                    POS_HUM_LO:  hum_word[7:0] = rx_byte;
                    POS_TEMP_HI: temp_word[15:8] = rx_byte;
                    POS_TEMP_LO: temp_word[7:0] = rx_byte;
                    POS_CRC_LO:  crc_lo_rx = rx_byte;
                    default:
                    begin
                        rx_crc = {rx_byte, crc_lo_rx};
                        want.humidity = '0;
                        want.temperature = '0;
                        if (hdr_err) begin
                            want.status = STATUS_HEADER;
                        end else if (rx_crc != crc_run) begin
                            want.status = STATUS_CRC;
                        end else begin
                            want.status = STATUS_OK;
                            want.humidity = hum_word;
                            // sign-magnitude to two's complement; negative zero stays 0
                            if (temp_word[SIGN_BIT]) begin
                                want.temperature = 16'h0000 - {1'b0, temp_word[14:0] & MAG_MASK};
                            end else begin
                                want.temperature = {1'b0, temp_word[14:0] & MAG_MASK};
                            end
                        end
                        expected_readings.push_back(want);
                        crc_run = CRC_INIT;
                        hdr_err = 1'b0;
                    end
                endcase
                next_pos = (pos == POS_CRC_HI) ? POS_FUNC : pos + 3'd1;
            end
            pending_readings <= expected_readings.size();
        end
    end

endmodule

`default_nettype wire

[sim/sensor_frame_crc_check_test.sv]
// Top of the sensor frame checker testbench: clock, reset, reply stimulus and verdict.
`default_nettype none

module sensor_frame_crc_check_test;
    import scc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_BYTES = 290;

    typedef enum int {
        REPLY_GOOD,
        REPLY_BAD_HEADER,
        REPLY_BAD_BOTH,
        REPLY_BAD_CRC,
        REPLY_CUT,
        REPLY_NOISE
    } reply_kind_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte = 8'h00;
    logic               frame_start = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         frame_status;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;

    int mismatches;
    int pending_readings;
    int readings_checked;

    int cycle_count = 0;
    int bytes_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    logic in_frame_sync = 1'b0;

    sensor_frame_crc_check u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .rx_byte            (rx_byte),
        .frame_start        (frame_start),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .frame_status       (frame_status),
        .humidity_tenths    (humidity_tenths),
        .temperature_tenths (temperature_tenths)
    );

    sensor_frame_crc_check_monitor u_mon (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .rx_byte            (rx_byte),
        .frame_start        (frame_start),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .frame_status       (frame_status),
        .humidity_tenths    (humidity_tenths),
        .temperature_tenths (temperature_tenths),
        .fail_count         (mismatches),
        .pending_readings   (pending_readings),
        .readings_checked   (readings_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_ack != hold_req) begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one word, with random idle cycles ahead of it, and wait until taken
    task automatic send_byte(input logic [7:0] value, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= value;
        frame_start <= start;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        bytes_sent = bytes_sent + 1;
    endtask

    // Stop sending until every expected reading has come back
    task automatic drain_readings();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_readings != 0) begin
            @(posedge clk);
        end
    endtask

    // Mostly random words, with the corner values showing up often
    function automatic logic [15:0] pick_word();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            default: return r[15:0];
        endcase
    endfunction

    // Build one reply, damage it as the kind says, and send it
    task automatic send_reply(input reply_kind_t kind, input logic [15:0] hum,
                              input logic [15:0] temp, input logic start);
        logic [0:7][7:0] reply;
        logic [15:0]     crc;
        logic [7:0]      flip;
        int              len;
        int              idx;
        if (kind == REPLY_NOISE) begin
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++) begin
                send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
            end
            in_frame_sync = 1'b0;
        end else begin
            reply[0] = HDR_FUNC;
            reply[1] = HDR_COUNT;
            reply[2] = hum[15:8];
            reply[3] = hum[7:0];
            reply[4] = temp[15:8];
            reply[5] = temp[7:0];
            if (kind == REPLY_BAD_HEADER || kind == REPLY_BAD_BOTH) begin
                idx = $urandom_range(1);
                flip = 8'($urandom_range(255, 1));
                reply[idx] = reply[idx] ^ flip;
            end
            crc = CRC_INIT;
            for (int i = 0; i < 6; i++) begin
                crc = crc ^ {8'h00, reply[i]};
                for (int k = 0; k < 8; k++) begin
                    crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
                end
            end
            reply[6] = crc[7:0];
            reply[7] = crc[15:8];
            if (kind == REPLY_BAD_CRC || kind == REPLY_BAD_BOTH) begin
                idx = 6 + $urandom_range(1);
                flip = 8'($urandom_range(255, 1));
                reply[idx] = reply[idx] ^ flip;
            end
            len = (kind == REPLY_CUT) ? $urandom_range(7, 1) : 8;
            for (int i = 0; i < len; i++) begin
                send_byte(reply[i], (i == 0) && start);
            end
            in_frame_sync = (kind != REPLY_CUT);
        end
    endtask

    initial
    begin : stimulus
        int          phase_goal;
        int          r;
        int          idle_now;
        reply_kind_t kind;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full-scale humidity with negative zero, then a back-to-back
        // frame at the most negative temperature, a dropped partial frame,
        // and a reply with both header and CRC wrong
        send_reply(REPLY_GOOD, 16'hFFFF, 16'h8000, 1'b1);
        send_reply(REPLY_GOOD, 16'h0000, 16'hFFFF, 1'b0);
        send_reply(REPLY_CUT, 16'h1234, 16'h0123, 1'b0);
        send_reply(REPLY_BAD_BOTH, 16'h5A5A, 16'h7FFF, 1'b1);
        drain_readings();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:
                begin
                    idle_now = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    idle_now = 58;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    idle_now = 0;
                    recv_stall_pct <= 58;
                end
                default:
                begin
                    idle_now = 38;
                    recv_stall_pct <= 38;
                end
            endcase

            // Long receiver hold-off while full frames are offered back to back
            hold_req <= hold_req + 1;
            send_idle_pct = 0;
            repeat (6) begin
                send_reply(REPLY_GOOD, pick_word(), pick_word(), !in_frame_sync);
            end
            send_idle_pct = idle_now;

            phase_goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_goal) begin
                r = $urandom_range(99);
                if (r < 60) begin
                    kind = REPLY_GOOD;
                end else if (r < 68) begin
                    kind = REPLY_BAD_HEADER;
                end else if (r < 73) begin
                    kind = REPLY_BAD_BOTH;
                end else if (r < 83) begin
                    kind = REPLY_BAD_CRC;
                end else if (r < 92) begin
                    kind = REPLY_CUT;
                end else begin
                    kind = REPLY_NOISE;
                end
                send_reply(kind, pick_word(), pick_word(),
                           !in_frame_sync || ($urandom_range(1) == 1));
            end
            drain_readings();
        end

        repeat (8) @(posedge clk);
        $display("Sent %0d reply bytes; %0d readings checked (good, bad header, bad CRC,",
                 bytes_sent, readings_checked);
        $display("cut and noisy frames) across four idle/stall mixes with long hold-offs.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
